/* rtl/dpms_pkg.sv */
// ============================================================================
// dpms_pkg
// Shared types and constants for the two-axis damped point mass stepper.
// ============================================================================
`default_nettype none

package dpms_pkg;

  // Default values for the top-level parameters.
  localparam int POS_BITS_DEF      = 10;
  localparam int VEL_FRAC_BITS_DEF = 16;

  // Fixed field widths.
  localparam int FORCE_W     = 7;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int VEL_W       = 32;
  localparam int LIM_W       = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Acceleration gain applied to a force command.
  localparam int FORCE_GAIN = 25;

  // Window clamp offsets.
  localparam int X_HI_TEST_OFS = 3;
  localparam int X_HI_VAL_OFS  = 4;
  localparam int Y_HI_VAL_OFS  = 2;
  localparam int LOW_CLAMP_POS = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] MAX_X_RST = 10'd80;
  localparam logic [CFG_W-1:0] MAX_Y_RST = 10'd24;
  localparam logic [CFG_W-1:0] START_RST = 10'd2;

  // Clamp codes.
  localparam logic [LIM_W-1:0] LIM_NONE = 2'd0;
  localparam logic [LIM_W-1:0] LIM_HIGH = 2'd1;
  localparam logic [LIM_W-1:0] LIM_LOW  = 2'd2;

  // Step enables from the sequencer to the lanes.
  typedef struct packed {
    logic mul_en;
    logic damp_en;
    logic vel_en;
    logic pmul_en;
    logic pos_en;
  } dpms_ctrl_t;

endpackage

`default_nettype wire

/* rtl/dpms_lane.sv */
// ============================================================================
// dpms_lane
// One axis: velocity update with damping and saturation, then position
// update with rounding and window clamp.
// ============================================================================
`default_nettype none

module dpms_lane #(
  parameter int POS_BITS      = dpms_pkg::POS_BITS_DEF,
  parameter int VEL_FRAC_BITS = dpms_pkg::VEL_FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire dpms_pkg::dpms_ctrl_t            ctrl_i,
  input  wire logic signed [dpms_pkg::FORCE_W-1:0] force_i,
  input  wire                                  load_i,
  input  wire [dpms_pkg::CFG_W-1:0]            load_val_i,
  input  wire logic signed [11:0]              hi_test_i,
  input  wire [dpms_pkg::CFG_W-1:0]            hi_val_i,
  output logic [dpms_pkg::CFG_W-1:0]           pos_o,
  output logic [dpms_pkg::LIM_W-1:0]           lim_o,
  output logic                                 sat_o
);

  localparam int F     = VEL_FRAC_BITS;
  localparam int TQ    = ((1 << F) + 5) / 10;
  localparam int DQ    = ((1 << F) + 50) / 100;
  localparam int CW    = F + 1;
  localparam int KW    = F + 6;
  localparam int ACC_W = dpms_pkg::FORCE_W + KW;
  localparam int DP_W  = dpms_pkg::VEL_W + CW;
  localparam int PP_W  = dpms_pkg::VEL_W + CW;
  localparam int DQ_W  = DP_W - F;
  localparam int PQ_W  = PP_W - 2 * F;
  localparam int NV_W  = 40;
  localparam int SUM_W = PQ_W + POS_BITS + 2;

  localparam logic signed [CW-1:0]   TQC   = CW'(TQ);
  localparam logic signed [CW-1:0]   DQC   = CW'(DQ);
  localparam logic signed [KW-1:0]   KGAIN = KW'(dpms_pkg::FORCE_GAIN * TQ);
  localparam logic signed [NV_W-1:0] VMAX  = {{(NV_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [NV_W-1:0] VMIN  = {{(NV_W-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [SUM_W-1:0] PMAX =
    {{(SUM_W-POS_BITS){1'b0}}, {POS_BITS{1'b1}}};

  logic signed [ACC_W-1:0]         acc_q;
  logic signed [DP_W-1:0]          dprod_q;
  logic signed [NV_W-1:0]          damp_q;
  logic signed [dpms_pkg::VEL_W-1:0] vel_q;
  logic                            sat_q;
  logic signed [PP_W-1:0]          pprod_q;
  logic [POS_BITS-1:0]             pos_q;

  // Damping rounding.
  logic signed [DQ_W-1:0] dmp_quo;
  logic [F-1:0]           dmp_rem;
  logic                   dmp_inc;
  logic signed [NV_W-1:0] damp_d;

  // Velocity update.
  logic signed [NV_W-1:0]            nv;
  logic signed [dpms_pkg::VEL_W-1:0] vel_d;
  logic                              sat_d;

  // Position update.
  logic signed [PQ_W-1:0]  pos_quo;
  logic [2*F-1:0]          pos_rem;
  logic signed [SUM_W-1:0] psum;
  logic                    pos_inc;
  logic signed [SUM_W-1:0] pround;
  logic signed [SUM_W-1:0] pclamp;
  logic [dpms_pkg::LIM_W-1:0] lim_d;
  logic signed [SUM_W-1:0] pfinal;
  logic [POS_BITS-1:0]     pos_d;
  logic signed [SUM_W-1:0] load_ext;
  logic [POS_BITS-1:0]     load_pos;
  logic signed [SUM_W-1:0] pos_ext;

  always_comb begin
    dmp_quo = dprod_q[DP_W-1:F];
    dmp_rem = dprod_q[F-1:0];
    // Half away from zero: ties move up when the floor is non-negative.
    if (dmp_quo[DQ_W-1]) begin
      dmp_inc = dmp_rem[F-1] && (|dmp_rem[F-2:0]);
    end else begin
      dmp_inc = dmp_rem[F-1];
    end
    damp_d = NV_W'(dmp_quo) + NV_W'($signed({1'b0, dmp_inc}));
  end

  always_comb begin
    nv = NV_W'(vel_q) + NV_W'(acc_q) - damp_q;
    sat_d = 1'b0;
    if (nv > VMAX) begin
      vel_d = VMAX[dpms_pkg::VEL_W-1:0];
      sat_d = 1'b1;
    end else if (nv < VMIN) begin
      vel_d = VMIN[dpms_pkg::VEL_W-1:0];
      sat_d = 1'b1;
    end else begin
      vel_d = nv[dpms_pkg::VEL_W-1:0];
    end
  end

  always_comb begin
    pos_quo = pprod_q[PP_W-1:2*F];
    pos_rem = pprod_q[2*F-1:0];
    psum    = SUM_W'($signed({1'b0, pos_q})) + SUM_W'(pos_quo);
    if (psum[SUM_W-1]) begin
      pos_inc = pos_rem[2*F-1] && (|pos_rem[2*F-2:0]);
    end else begin
      pos_inc = pos_rem[2*F-1];
    end
    pround = psum + SUM_W'($signed({1'b0, pos_inc}));
    if (pround >= SUM_W'(hi_test_i)) begin
      pclamp = SUM_W'($signed({1'b0, hi_val_i}));
      lim_d  = dpms_pkg::LIM_HIGH;
    end else if (pround <= SUM_W'(1)) begin
      pclamp = SUM_W'(dpms_pkg::LOW_CLAMP_POS);
      lim_d  = dpms_pkg::LIM_LOW;
    end else begin
      pclamp = pround;
      lim_d  = dpms_pkg::LIM_NONE;
    end
    pfinal = (pclamp > PMAX) ? PMAX : pclamp;
    pos_d  = pfinal[POS_BITS-1:0];

    load_ext = SUM_W'($signed({1'b0, load_val_i}));
    load_pos = (load_ext > PMAX) ? PMAX[POS_BITS-1:0] : load_ext[POS_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      acc_q   <= ACC_W'(force_i) * ACC_W'(KGAIN);
      dprod_q <= DP_W'(vel_q) * DP_W'(DQC);
    end
    if (ctrl_i.damp_en) begin
      damp_q <= damp_d;
    end
    if (ctrl_i.pmul_en) begin
      pprod_q <= PP_W'(vel_q) * PP_W'(TQC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      sat_q <= 1'b0;
      pos_q <= POS_BITS'(dpms_pkg::START_RST);
    end else begin
      if (ctrl_i.vel_en) begin
        vel_q <= vel_d;
        sat_q <= sat_d;
      end
      if (load_i) begin
        pos_q <= load_pos;
      end else if (ctrl_i.pos_en) begin
        pos_q <= pos_d;
      end
    end
  end

  always_comb begin
    pos_ext = SUM_W'($signed({1'b0, pos_d}));
    pos_o   = pos_ext[dpms_pkg::CFG_W-1:0];
    lim_o   = lim_d;
    sat_o   = sat_q;
  end

endmodule

`default_nettype wire

/* rtl/dpms_seq.sv */
// ============================================================================
// dpms_seq
// Step sequencer: walks one accepted item through the lane steps.
// ============================================================================
`default_nettype none

module dpms_seq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  out_free_i,
  output logic                 in_ready_o,
  output dpms_pkg::dpms_ctrl_t ctrl_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DAMP = 3'd1;
  localparam logic [2:0] ST_VEL  = 3'd2;
  localparam logic [2:0] ST_PMUL = 3'd3;
  localparam logic [2:0] ST_POS  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.mul_en = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DAMP;
        end
      end
      ST_DAMP: begin
        ctrl_o.damp_en = 1'b1;
        state_d        = ST_VEL;
      end
      ST_VEL: begin
        ctrl_o.vel_en = 1'b1;
        state_d       = ST_PMUL;
      end
      ST_PMUL: begin
        ctrl_o.pmul_en = 1'b1;
        state_d        = ST_POS;
      end
      ST_POS: begin
        // Hold here while the previous result still sits in the output register.
        ctrl_o.pos_en = out_free_i;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/damped_point_mass_step_2d.sv */
// ============================================================================
// damped_point_mass_step_2d
// Two-axis point mass advanced by one Euler tick per input transfer.
// ============================================================================
//
//  Channel   Dir  Handshake          Payload
//  s_axis    in   tvalid / tready    tdata: force_x, force_y
//  m_axis    out  tvalid / tready    tdata: pos_x, pos_y, limit_x, limit_y, vel_sat
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (max_x, max_y, start_x, start_y)
//
// The accepting edge forms the force and damping products; the sequencer
// then steps through the damping round, the velocity add with saturation,
// the position product and the rounded, clamped position, which is
// registered into the output. The step sequencer handles one item at a
// time, so a new item is taken only once the previous one has left the
// final step. Reset clears both velocities, loads the register defaults
// and sets both positions to the start value. A stalled output holds only
// the final position step; the next item is still accepted while a result waits.
//
`default_nettype none

module damped_point_mass_step_2d #(
  parameter int POS_BITS      = dpms_pkg::POS_BITS_DEF,
  parameter int VEL_FRAC_BITS = dpms_pkg::VEL_FRAC_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // [6:0] force_x, [13:7] force_y, [15:14] zero
  input  wire [dpms_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [9:0] pos_x, [19:10] pos_y, [21:20] limit_x, [23:22] limit_y,
  // [24] vel_sat, [31:25] zero
  output logic [dpms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  input  wire                                cfg_we_i,
  input  wire [dpms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [dpms_pkg::CFG_W-1:0]          cfg_data_i
);

  // Configuration registers.
  logic [dpms_pkg::CFG_W-1:0] max_x_q, max_y_q, start_x_q, start_y_q;

  // Clamp bounds derived from the window registers.
  logic signed [11:0]         hi_test_x, hi_test_y;
  logic [dpms_pkg::CFG_W-1:0] hi_val_x, hi_val_y;

  logic                 ready;
  logic                 out_free;
  dpms_pkg::dpms_ctrl_t ctrl;

  logic [dpms_pkg::CFG_W-1:0] pos_x, pos_y;
  logic [dpms_pkg::LIM_W-1:0] lim_x, lim_y;
  logic                       sat_x, sat_y;

  logic                                out_valid_q;
  logic [dpms_pkg::OUT_TDATA_W-1:0]    out_data_q;

  logic load_x, load_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q   <= dpms_pkg::MAX_X_RST;
      max_y_q   <= dpms_pkg::MAX_Y_RST;
      start_x_q <= dpms_pkg::START_RST;
      start_y_q <= dpms_pkg::START_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpms_pkg::REG_MAX_X:   max_x_q   <= cfg_data_i;
        dpms_pkg::REG_MAX_Y:   max_y_q   <= cfg_data_i;
        dpms_pkg::REG_START_X: start_x_q <= cfg_data_i;
        dpms_pkg::REG_START_Y: start_y_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A start write also loads the lane's stored position.
  assign load_x = cfg_we_i && (cfg_idx_i == dpms_pkg::REG_START_X);
  assign load_y = cfg_we_i && (cfg_idx_i == dpms_pkg::REG_START_Y);

  // On x the high test is max_x-3 and the clamp value max_x-4; on y they are
  // max_y and max_y-2. A clamp value that would go negative becomes zero.
  always_comb begin
    hi_test_x = $signed({2'b00, max_x_q}) - 12'(dpms_pkg::X_HI_TEST_OFS);
    hi_test_y = $signed({2'b00, max_y_q});
    hi_val_x  = (max_x_q < dpms_pkg::CFG_W'(dpms_pkg::X_HI_VAL_OFS)) ? '0 :
                max_x_q - dpms_pkg::CFG_W'(dpms_pkg::X_HI_VAL_OFS);
    hi_val_y  = (max_y_q < dpms_pkg::CFG_W'(dpms_pkg::Y_HI_VAL_OFS)) ? '0 :
                max_y_q - dpms_pkg::CFG_W'(dpms_pkg::Y_HI_VAL_OFS);
  end

  // The final step may fire only when the output register can take it.
  assign out_free = !out_valid_q || m_axis_tready_i;

  dpms_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .in_ready_o (ready),
    .ctrl_o     (ctrl)
  );

  dpms_lane #(
    .POS_BITS      (POS_BITS),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .force_i    ($signed(s_axis_tdata_i[6:0])),
    .load_i     (load_x),
    .load_val_i (cfg_data_i),
    .hi_test_i  (hi_test_x),
    .hi_val_i   (hi_val_x),
    .pos_o      (pos_x),
    .lim_o      (lim_x),
    .sat_o      (sat_x)
  );

  dpms_lane #(
    .POS_BITS      (POS_BITS),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .force_i    ($signed(s_axis_tdata_i[13:7])),
    .load_i     (load_y),
    .load_val_i (cfg_data_i),
    .hi_test_i  (hi_test_y),
    .hi_val_i   (hi_val_y),
    .pos_o      (pos_y),
    .lim_o      (lim_y),
    .sat_o      (sat_y)
  );

  // Merge the two lanes into one result word; saturation on either axis
  // raises vel_sat.
  always_ff @(posedge clk_i) begin
    if (ctrl.pos_en) begin
      out_data_q <= {7'd0, sat_x | sat_y, lim_y, lim_x, pos_y, pos_x};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.pos_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign s_axis_tready_o = ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Unused padding bits of the input word.
  logic unused_in;
  assign unused_in = ^s_axis_tdata_i[15:14];

endmodule

`default_nettype wire

/* rtl/dpms_checker.sv */
// ============================================================================
// dpms_checker
// Port-level checks for the damped point mass stepper, bound to the top level.
// ============================================================================
`default_nettype none

module dpms_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire [dpms_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input wire                              s_axis_tvalid_i,
  input wire                              s_axis_tready_o,
  input wire [dpms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input wire                              m_axis_tvalid_o,
  input wire                              m_axis_tready_i
);

  logic unused_data;
  assign unused_data = ^s_axis_tdata_i;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // One item at a time: after a transfer the input side is busy.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  // A low clamp always yields position 2 on x.
  a_low_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[21:20] == dpms_pkg::LIM_LOW
      |-> m_axis_tdata_o[9:0] == 10'd2)
    else $error("x low clamp with wrong position");

  // A low clamp always yields position 2 on y.
  a_low_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[23:22] == dpms_pkg::LIM_LOW
      |-> m_axis_tdata_o[19:10] == 10'd2)
    else $error("y low clamp with wrong position");

endmodule

bind damped_point_mass_step_2d dpms_checker u_dpms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for damped_point_mass_step_2d
// Drives force ticks on the input stream and checks every output transfer
// against a cycle-free predictor of the damped point mass. The predictor keeps
// its own velocities in Q15.16 and its own positions and window registers.
// ----------------------------------------------------------------------------

module tb;
  import dpms_pkg::*;

  // The run is cut off here.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 150;
  localparam int PHASES = 12;
  localparam int PHASE_TICKS = 155;

  // Fixed-point constants of the integrator, derived from the velocity format.
  localparam longint TICK_Q  = ((longint'(1) << VEL_FRAC_BITS_DEF) + 5) / 10;
  localparam longint DAMP_Q  = ((longint'(1) << VEL_FRAC_BITS_DEF) + 50) / 100;
  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;
  localparam longint POS_MAX = (longint'(1) << POS_BITS_DEF) - 1;

  // One result transfer; the packing matches tdata from bit 0 up.
  typedef struct packed {
    logic            vel_sat;
    logic [LIM_W-1:0] limit_y;
    logic [LIM_W-1:0] limit_x;
    logic [9:0]       pos_y;
    logic [9:0]       pos_x;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predictor state: velocity and position per axis (0 is x, 1 is y) and a
  // copy of the window registers.
  longint vel_q[2];
  longint pos_st[2];
  logic [CFG_W-1:0] win_max_x = MAX_X_RST;
  logic [CFG_W-1:0] win_max_y = MAX_Y_RST;
  logic tick_sat;

  // Positions the block still owes us, oldest first.
  tick_result_t expected_ticks[$];

  // Knobs shared by the stimulus tasks and the result process.
  bit in_idle = 1'b0;
  bit out_idle = 1'b0;
  int hold_request = 0;
  int stall_left = 0;

  int fail_count = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int high_clamps = 0;
  int low_clamps = 0;
  int cycle_count = 0;

  tick_result_t got_tick;
  tick_result_t want_tick;

  damped_point_mass_step_2d dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),   // [6:0] force_x, [13:7] force_y, [15:14] zero
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),   // [9:0] pos_x, [19:10] pos_y, [21:20] limit_x,
                                  // [23:22] limit_y, [24] vel_sat, [31:25] zero
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // base + prod / 2^sh with the whole sum rounded half away from zero. The
  // arithmetic shift floors, so the remainder is never negative; a negative
  // sum only rounds up when the remainder is strictly above one half.
  function automatic longint round_add(input longint base, input longint prod,
                                       input int sh);
    longint quo;
    longint rem;
    longint sum;
    longint half;
    quo = prod >>> sh;
    rem = prod - (quo <<< sh);
    sum = base + quo;
    half = longint'(1) << (sh - 1);
    if (sum >= 0)
      return sum + ((rem >= half) ? 1 : 0);
    return sum + ((rem > half) ? 1 : 0);
  endfunction

  function automatic longint clamp_pos(input longint p);
    if (p < 0)
      return 0;
    if (p > POS_MAX)
      return POS_MAX;
    return p;
  endfunction

  // One Euler tick on one axis. Velocity saturates to 32 bits and is left
  // alone by a window clamp; the high bound is tested before the low one.
  function automatic logic [LIM_W-1:0] step_axis(input int ax, input logic [6:0] force_raw,
                                                 input longint hi_test, input longint hi_val);
    longint accel;
    longint damp;
    longint nv;
    longint p;
    logic [LIM_W-1:0] lim;
    accel = longint'($signed(force_raw)) * FORCE_GAIN;
    damp = round_add(0, vel_q[ax] * DAMP_Q, VEL_FRAC_BITS_DEF);
    nv = vel_q[ax] + accel * TICK_Q - damp;
    if (nv > VEL_MAX) begin
      nv = VEL_MAX;
      tick_sat = 1'b1;
    end else if (nv < VEL_MIN) begin
      nv = VEL_MIN;
      tick_sat = 1'b1;
    end
    vel_q[ax] = nv;
    p = round_add(pos_st[ax], nv * TICK_Q, 2 * VEL_FRAC_BITS_DEF);
    lim = LIM_NONE;
    if (p >= hi_test) begin
      // A tiny window would give a negative bound; it stops at zero.
      p = (hi_val < 0) ? 0 : hi_val;
      lim = LIM_HIGH;
    end else if (p <= 1) begin
      p = LOW_CLAMP_POS;
      lim = LIM_LOW;
    end
    pos_st[ax] = clamp_pos(p);
    return lim;
  endfunction

  function automatic tick_result_t predict_tick(input logic [6:0] fx, input logic [6:0] fy);
    tick_result_t res;
    tick_sat = 1'b0;
    res.limit_x = step_axis(0, fx, longint'(win_max_x) - X_HI_TEST_OFS,
                            longint'(win_max_x) - X_HI_VAL_OFS);
    res.limit_y = step_axis(1, fy, longint'(win_max_y), longint'(win_max_y) - Y_HI_VAL_OFS);
    res.pos_x = 10'(pos_st[0]);
    res.pos_y = 10'(pos_st[1]);
    res.vel_sat = tick_sat;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, the long hold, and the field-by-field check.
  // --------------------------------------------------------------------------

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      got_tick = m_tdata[24:0];
      results_seen++;
      if (expected_ticks.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
        fail_count++;
      end else begin
        want_tick = expected_ticks.pop_front();
        check_field("pos_x", want_tick.pos_x, got_tick.pos_x);
        check_field("pos_y", want_tick.pos_y, got_tick.pos_y);
        check_field("limit_x", want_tick.limit_x, got_tick.limit_x);
        check_field("limit_y", want_tick.limit_y, got_tick.limit_y);
        check_field("vel_sat", want_tick.vel_sat, got_tick.vel_sat);
      end
      if (got_tick.limit_x == LIM_HIGH || got_tick.limit_y == LIM_HIGH)
        high_clamps++;
      if (got_tick.limit_x == LIM_LOW || got_tick.limit_y == LIM_LOW)
        low_clamps++;
      stall_left = out_idle ? $urandom_range(0, 8) : 0;
    end
    // A long hold replaces whatever stall was drawn, so the block backs up.
    if (hold_request != 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends on a rising edge, and each
  // edge sees at most one assignment to tvalid.
  // --------------------------------------------------------------------------

  // Offers one force tick and books its predicted result at the transfer.
  task automatic send_force(input logic [6:0] fx, input logic [6:0] fy);
    int gap;
    gap = in_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, fy, fx};
    do @(posedge clk); while (!s_tready);
    expected_ticks.push_back(predict_tick(fx, fy));
    ticks_sent++;
  endtask

  // Registers change only once the block has handed back every result and
  // has had time to settle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_X: win_max_x = value;
      REG_MAX_Y: win_max_y = value;
      REG_START_X: pos_st[0] = clamp_pos(longint'(value));
      REG_START_Y: pos_st[1] = clamp_pos(longint'(value));
      default: ;
    endcase
    reg_writes++;
  endtask

  // Mostly gentle pushes so positions wander inside the window; the rest
  // spans the whole 7-bit field, including values beyond the nominal range.
  function automatic logic [6:0] pick_force();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6)
      return 7'($urandom_range(0, 8) - 4);
    if (sel < 8)
      return 7'($urandom_range(0, 64) - 32);
    return 7'($urandom_range(0, 127));
  endfunction

  // Window bounds: tiny ones below the nominal range, the top value, and
  // ordinary sizes.
  function automatic logic [CFG_W-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return CFG_W'($urandom_range(0, 7));
      1: return {CFG_W{1'b1}};
      2: return CFG_W'($urandom_range(8, 40));
      default: return CFG_W'($urandom_range(8, 1023));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Full-scale pushes from the reset state drive both axes into the high
  // and the low bound of the default window; then the motion coasts.
  task automatic test_force_extremes();
    repeat (4) send_force(7'sd63, -7'sd64);
    repeat (3) send_force(-7'sd64, 7'sd63);
    send_force(7'sd32, -7'sd32);
    send_force(-7'sd32, 7'sd32);
    send_force(7'sd1, -7'sd1);
    send_force(7'sd0, 7'sd0);
  endtask

  // Windows so small that the high clamp value would go negative, and the
  // largest window with start positions at both ends of the register.
  task automatic test_window_corners();
    write_reg(REG_MAX_X, 10'd3);
    write_reg(REG_MAX_Y, 10'd1);
    send_force(7'sd5, -7'sd5);
    send_force(-7'sd64, 7'sd63);
    write_reg(REG_MAX_X, 10'd0);
    write_reg(REG_MAX_Y, 10'd0);
    send_force(7'sd0, 7'sd0);
    write_reg(REG_MAX_X, 10'd4);
    write_reg(REG_MAX_Y, 10'd2);
    send_force(7'sd2, 7'sd2);
    write_reg(REG_MAX_X, 10'd1023);
    write_reg(REG_MAX_Y, 10'd1023);
    write_reg(REG_START_X, 10'd1023);
    write_reg(REG_START_Y, 10'd0);
    send_force(7'sd0, 7'sd0);
    send_force(-7'sd64, 7'sd63);
    write_reg(REG_START_X, 10'd1);
    write_reg(REG_START_Y, 10'd512);
    send_force(7'sd0, 7'sd0);
  endtask

  // The receiver holds off while the sender keeps offering back to back,
  // so the block fills and stalls its input. Afterwards the sender pauses
  // until every result is back before carrying on.
  task automatic test_output_backpressure();
    in_idle = 1'b0;
    out_idle = 1'b0;
    hold_request = LONG_HOLD;
    repeat (30) send_force(pick_force(), pick_force());
    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    in_idle = 1'b1;
    out_idle = 1'b1;
    repeat (10) send_force(pick_force(), pick_force());
  endtask

  // Random phases, each with its own window and its own idling pattern.
  // Start positions are reloaded in about half the phases, so velocity
  // carries across a jump in position.
  task automatic test_random_motion();
    int phase;
    for (phase = 0; phase < PHASES; phase++) begin
      write_reg(REG_MAX_X, pick_bound());
      write_reg(REG_MAX_Y, pick_bound());
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_START_X, CFG_W'($urandom_range(0, 1023)));
        write_reg(REG_START_Y, CFG_W'($urandom_range(0, 1023)));
      end
      in_idle = (phase % 4 == 0) || (phase % 4 == 2);
      out_idle = (phase % 4 == 0) || (phase % 4 == 3);
      repeat (PHASE_TICKS) send_force(pick_force(), pick_force());
    end
  endtask

  initial begin
    vel_q[0] = 0;
    vel_q[1] = 0;
    pos_st[0] = START_RST;
    pos_st[1] = START_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_force_extremes();
    test_window_corners();
    test_output_backpressure();
    test_random_motion();

    s_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 3) @(posedge clk);

    $display("Covered %0d force ticks and %0d results, %0d register writes,",
             ticks_sent, results_seen, reg_writes);
    $display("with %0d high-bound and %0d low-bound clamps across the windows.",
             high_clamps, low_clamps);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
